// ===== hw/rtl/spimv_pkg.sv =====
// Shared types and constants for the SPI mode 0 master with verify.
// Used by every module under hw/rtl; depends on nothing else.
package spimv_pkg;

    // Widths and reset values.
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int HALF_WIDTH = 16;
    localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET = 16'd1;

    // Item opcodes.
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // Byte modes.
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_VERIFY = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // One input beat.
    typedef struct packed {
        logic [1:0] opcode;
        logic       cs_select;
        logic       lcd_command;
        logic       lcd_release;
        logic [1:0] byte_mode;
        logic [7:0] tx_byte;
        logic       touch_data_in;
        logic       lcd_data_in;
    } req_beat_t;

    // One result beat.
    typedef struct packed {
        logic        sck;
        logic        mosi;
        logic        mosi_drive;
        logic        lcd_cs_n;
        logic        touch_cs_n;
        logic        dcx;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        mismatch;
        logic        busy_res;
        logic [15:0] bytes_done;
    } rsp_beat_t;

    // Line and status flags of the transfer.
    typedef struct packed {
        logic lcd_cs_n;
        logic touch_cs_n;
        logic dcx;
        logic released;
        logic mismatch;
        logic shifting;
    } flags_t;

endpackage

// ===== hw/rtl/spimv_core.sv =====
// Transfer state and per-beat update logic of the SPI master.
// Depends on spimv_pkg for beat types, opcodes and byte modes.
module spimv_core #(
    parameter int COUNT_WIDTH = spimv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spimv_pkg::HALF_WIDTH-1:0]    cfg_data,
    input  logic                                item_valid,
    input  spimv_pkg::req_beat_t                item,
    output spimv_pkg::rsp_beat_t                result
);

    localparam int HW = spimv_pkg::HALF_WIDTH;

    logic [HW-1:0]          half_reg;
    logic [7:0]             shift_out_reg, shift_out_next;
    logic [7:0]             shift_in_reg, shift_in_next;
    logic [2:0]             bit_index_reg, bit_index_next;
    logic                   half_phase_reg, half_phase_next;
    logic [HW-1:0]          wait_reg, wait_next;
    spimv_pkg::flags_t      flags_reg, flags_next;
    logic [1:0]             mode_reg, mode_next;
    logic [7:0]             expected_reg, expected_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             last_rx_reg, last_rx_next;

    logic [HW-1:0] half_ticks;
    logic [HW-1:0] wait_dec;
    logic          selected;
    logic          pin_bit;
    logic          rx_valid;
    logic [1:0]    new_mode;
    logic [31:0]   count_ext;

    // A zero half period behaves as one tick.
    assign half_ticks = (half_reg == '0) ? HW'(1) : half_reg;
    assign wait_dec   = wait_reg - HW'(1);
    assign selected   = !(flags_reg.lcd_cs_n && flags_reg.touch_cs_n);
    assign pin_bit    = flags_reg.released ? item.lcd_data_in : item.touch_data_in;
    assign new_mode   = (item.byte_mode == spimv_pkg::MODE_SPARE)
                        ? spimv_pkg::MODE_WRITE : item.byte_mode;

    // Next state for one beat.
    always_comb
    begin
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        bit_index_next  = bit_index_reg;
        half_phase_next = half_phase_reg;
        wait_next       = wait_reg;
        flags_next      = flags_reg;
        mode_next       = mode_reg;
        expected_next   = expected_reg;
        count_next      = count_reg;
        last_rx_next    = last_rx_reg;
        rx_valid        = 1'b0;
        if (item_valid)
        begin
            case (item.opcode)
                spimv_pkg::OP_BEGIN:
                begin
                    // Restart unless a byte is on the wire.
                    if (!flags_reg.shifting)
                    begin
                        flags_next.lcd_cs_n   = item.cs_select;
                        flags_next.touch_cs_n = !item.cs_select;
                        flags_next.dcx        = !item.lcd_command;
                        flags_next.released   = item.lcd_release;
                        flags_next.mismatch   = 1'b0;
                        flags_next.shifting   = 1'b0;
                        count_next            = '0;
                        half_phase_next       = 1'b0;
                        wait_next             = half_ticks;
                    end
                end
                spimv_pkg::OP_BYTE:
                begin
                    // Start a byte only when selected, settled and not failed.
                    if (selected && !flags_reg.shifting && wait_reg == '0 &&
                        !flags_reg.mismatch)
                    begin
                        mode_next           = new_mode;
                        expected_next       = item.tx_byte;
                        shift_out_next      = (new_mode == spimv_pkg::MODE_VERIFY)
                                              ? 8'd0 : item.tx_byte;
                        bit_index_next      = 3'd7;
                        half_phase_next     = 1'b0;
                        wait_next           = half_ticks;
                        flags_next.shifting = 1'b1;
                    end
                end
                spimv_pkg::OP_TICK:
                begin
                    // Count down; at the end of a half period advance the clock.
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_dec;
                        if (flags_reg.shifting && wait_dec == '0)
                        begin
                            if (!half_phase_reg)
                            begin
                                half_phase_next = 1'b1;
                                wait_next       = half_ticks;
                            end
                            else
                            begin
                                half_phase_next = 1'b0;
                                if (mode_reg != spimv_pkg::MODE_WRITE)
                                begin
                                    shift_in_next = {shift_in_reg[6:0], pin_bit};
                                end
                                if (bit_index_reg != 3'd0)
                                begin
                                    bit_index_next = bit_index_reg - 3'd1;
                                    wait_next      = half_ticks;
                                end
                                else
                                begin
                                    flags_next.shifting = 1'b0;
                                    if (count_reg != '1)
                                    begin
                                        count_next = count_reg + COUNT_WIDTH'(1);
                                    end
                                    // Byte finished: report it in read and verify.
                                    if (mode_reg != spimv_pkg::MODE_WRITE)
                                    begin
                                        rx_valid     = 1'b1;
                                        last_rx_next = shift_in_next;
                                        if (mode_reg == spimv_pkg::MODE_VERIFY &&
                                            shift_in_next != expected_reg)
                                        begin
                                            flags_next.mismatch = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    // End of transfer releases all lines; mismatch is kept.
                    flags_next.lcd_cs_n   = 1'b1;
                    flags_next.touch_cs_n = 1'b1;
                    flags_next.dcx        = 1'b1;
                    flags_next.released   = 1'b0;
                    flags_next.shifting   = 1'b0;
                    wait_next             = '0;
                    half_phase_next       = 1'b0;
                end
            endcase
        end
    end

    // Result of the beat, taken from the updated state.
    assign count_ext = 32'(count_next);
    always_comb
    begin
        result.sck        = flags_next.shifting && half_phase_next;
        result.mosi       = shift_out_next[bit_index_next];
        result.mosi_drive = !flags_next.released;
        result.lcd_cs_n   = flags_next.lcd_cs_n;
        result.touch_cs_n = flags_next.touch_cs_n;
        result.dcx        = flags_next.dcx;
        result.rx_byte    = last_rx_next;
        result.rx_valid   = rx_valid;
        result.mismatch   = flags_next.mismatch;
        result.busy_res   = flags_next.shifting || wait_next != '0;
        result.bytes_done = (count_ext > 32'h0000_FFFF) ? 16'hFFFF : count_ext[15:0];
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg       <= spimv_pkg::HALF_PERIOD_RESET;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            bit_index_reg  <= 3'd7;
            half_phase_reg <= 1'b0;
            wait_reg       <= '0;
            flags_reg      <= '{lcd_cs_n: 1'b1, touch_cs_n: 1'b1, dcx: 1'b1,
                                released: 1'b0, mismatch: 1'b0, shifting: 1'b0};
            mode_reg       <= spimv_pkg::MODE_WRITE;
            expected_reg   <= '0;
            count_reg      <= '0;
            last_rx_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_reg <= cfg_data;
            end
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            bit_index_reg  <= bit_index_next;
            half_phase_reg <= half_phase_next;
            wait_reg       <= wait_next;
            flags_reg      <= flags_next;
            mode_reg       <= mode_next;
            expected_reg   <= expected_next;
            count_reg      <= count_next;
            last_rx_reg    <= last_rx_next;
        end
    end

endmodule

// ===== hw/rtl/spimv_out_buf.sv =====
// Two-entry result buffer that decouples the update logic from the receiver.
// Depends on spimv_pkg for the result beat type.
module spimv_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  spimv_pkg::rsp_beat_t push_data,
    output logic                 full,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output spimv_pkg::rsp_beat_t rsp_data
);

    logic [1:0]           count_reg, count_next;
    spimv_pkg::rsp_beat_t head_reg, head_next;
    spimv_pkg::rsp_beat_t skid_reg, skid_next;
    logic                 pop;

    assign pop       = (count_reg != 2'd0) && !rsp_stall;
    assign full      = (count_reg == 2'd2);
    assign rsp_valid = (count_reg != 2'd0);
    assign rsp_data  = head_reg;

    // Head holds the oldest beat, skid the one behind it.
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        if (pop)
        begin
            head_next = skid_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (pop && count_reg == 2'd1))
            begin
                head_next = push_data;
            end
            else
            begin
                skid_next = push_data;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Occupancy is control state; the entries need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hw/rtl/spi_mode0_master_with_verify.sv =====
// Top level of the SPI mode 0 master with verify mode.
// Depends on spimv_pkg, spimv_core and spimv_out_buf.
//
// Usage: each request beat on req_* is one item (begin, byte, tick or end)
// and produces exactly one result beat on rsp_* with the pin levels and
// status after that item. SCK timing is counted in tick items, with
// half_period_ticks (cfg_we/cfg_data) ticks per half period; write it only
// while no transfer is under way.
// Path: a request beat is taken into the input register, then applied to
// the state as its result beat is loaded into the output buffer, from
// which the receiver takes it when it does not stall.
// Throughput: one item per cycle while the result buffer has room.
// A two-entry result buffer lets requests keep flowing while one result
// waits; when the receiver stalls and the buffer fills, req_stall rises and
// the pending request holds in the input register.
// Reset (rst_n low) deselects both devices, drives dcx high, parks SCK low,
// clears counters and empties both the input register and the buffer.
module spi_mode0_master_with_verify #(
    parameter int COUNT_WIDTH = spimv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [spimv_pkg::HALF_WIDTH-1:0] cfg_data,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  spimv_pkg::req_beat_t             req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output spimv_pkg::rsp_beat_t             rsp_data
);

    logic                 in_valid_reg, in_valid_next;
    spimv_pkg::req_beat_t in_data_reg;
    logic                 buf_full;
    logic                 advance;
    logic                 accept;
    spimv_pkg::rsp_beat_t core_result;

    // Input register moves forward whenever the buffer has room.
    assign advance   = in_valid_reg && !buf_full;
    assign req_stall = in_valid_reg && buf_full;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= req_data;
        end
    end

    // State update for the registered beat.
    spimv_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (advance),
        .item       (in_data_reg),
        .result     (core_result)
    );

    // Result register with skid entry.
    spimv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (core_result),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== dv/spimv_checker.sv =====
`timescale 1ns / 1ps
// Checker for spi_mode0_master_with_verify: keeps its own copy of the SPI engine
// state, predicts one result beat per accepted request beat and compares them.
// Depends on spimv_pkg for the beat types, opcodes and byte modes.
module spimv_checker #(
    parameter int COUNT_WIDTH = spimv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [spimv_pkg::HALF_WIDTH-1:0] cfg_data,
    input  logic                             req_valid,
    input  logic                             req_stall,
    input  spimv_pkg::req_beat_t             req_data,
    input  logic                             rsp_valid,
    input  logic                             rsp_stall,
    input  spimv_pkg::rsp_beat_t             rsp_data,
    output int                               fail_count,
    output int                               pending,
    output int                               checked
);
    import spimv_pkg::*;

    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam int PRINT_MAX = 40;

    // Shadow copy of the engine state and the half-period register.
    logic [15:0]     half_cfg;
    logic [7:0]      sh_out;
    logic [7:0]      sh_in;
    logic [7:0]      last_rx;
    logic [7:0]      exp_byte;
    logic [2:0]      bit_pos;
    logic            phase;
    logic [15:0]     wait_cnt;
    flags_t          flg;
    logic [1:0]      cur_mode;
    longint unsigned byte_cnt;

    // Pin and status levels still owed by the block, oldest first.
    rsp_beat_t expected_pins_q[$];

    // A register value of zero behaves as one tick per half period.
    function automatic logic [15:0] half_len();
        return (half_cfg == 16'd0) ? 16'd1 : half_cfg;
    endfunction

    // Apply one item to the shadow state and return the levels after it.
    function automatic rsp_beat_t predict_pins(req_beat_t r);
        rsp_beat_t o;
        logic      was_shift;
        logic      sel;
        logic      pin;
        logic      keep_mm;
        o = '0;
        was_shift = flg.shifting;
        sel = !(flg.lcd_cs_n && flg.touch_cs_n);
        case (r.opcode)
            OP_BEGIN:
            begin
                // A begin during a byte is dropped; otherwise it restarts.
                if (!was_shift)
                begin
                    flg = '0;
                    flg.lcd_cs_n = r.cs_select;
                    flg.touch_cs_n = !r.cs_select;
                    flg.dcx = !r.lcd_command;
                    flg.released = r.lcd_release;
                    byte_cnt = 0;
                    phase = 1'b0;
                    wait_cnt = half_len();
                end
            end
            OP_BYTE:
            begin
                if (sel && !was_shift && wait_cnt == 16'd0 && !flg.mismatch)
                begin
                    cur_mode = (r.byte_mode == MODE_SPARE) ? MODE_WRITE : r.byte_mode;
                    exp_byte = r.tx_byte;
                    sh_out = (cur_mode == MODE_VERIFY) ? 8'h00 : r.tx_byte;
                    bit_pos = 3'd7;
                    phase = 1'b0;
                    wait_cnt = half_len();
                    flg.shifting = 1'b1;
                end
            end
            OP_TICK:
            begin
                pin = flg.released ? r.lcd_data_in : r.touch_data_in;
                // Count down; at zero, flip the SCK half or finish a bit.
                if (wait_cnt != 16'd0)
                begin
                    wait_cnt = wait_cnt - 16'd1;
                    if (flg.shifting && wait_cnt == 16'd0)
                    begin
                        if (!phase)
                        begin
                            phase = 1'b1;
                            wait_cnt = half_len();
                        end
                        else
                        begin
                            phase = 1'b0;
                            if (cur_mode != MODE_WRITE)
                                sh_in = {sh_in[6:0], pin};
                            if (bit_pos != 3'd0)
                            begin
                                bit_pos = bit_pos - 3'd1;
                                wait_cnt = half_len();
                            end
                            else
                            begin
                                flg.shifting = 1'b0;
                                if (byte_cnt < CNT_MAX)
                                    byte_cnt = byte_cnt + 1;
                            end
                        end
                    end
                end
                // A read or verify byte that just finished is reported.
                if (was_shift && !flg.shifting && cur_mode != MODE_WRITE)
                begin
                    o.rx_valid = 1'b1;
                    last_rx = sh_in;
                    if (cur_mode == MODE_VERIFY && sh_in != exp_byte)
                        flg.mismatch = 1'b1;
                end
            end
            OP_END:
            begin
                keep_mm = flg.mismatch;
                flg = '0;
                flg.lcd_cs_n = 1'b1;
                flg.touch_cs_n = 1'b1;
                flg.dcx = 1'b1;
                flg.mismatch = keep_mm;
                wait_cnt = 16'd0;
                phase = 1'b0;
            end
            default: ;
        endcase
        o.sck = flg.shifting && phase;
        o.mosi = sh_out[bit_pos];
        o.mosi_drive = !flg.released;
        o.lcd_cs_n = flg.lcd_cs_n;
        o.touch_cs_n = flg.touch_cs_n;
        o.dcx = flg.dcx;
        o.rx_byte = last_rx;
        o.mismatch = flg.mismatch;
        o.busy_res = flg.shifting || wait_cnt != 16'd0;
        o.bytes_done = (byte_cnt > 64'hFFFF) ? 16'hFFFF : 16'(byte_cnt);
        return o;
    endfunction

    // Print one line per failure, up to a cap, and count every one.
    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= PRINT_MAX)
            $display("ERROR result beat %0d: %s", checked, msg);
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Track configuration, score result beats, then predict new request beats.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            half_cfg = HALF_PERIOD_RESET;
            sh_out = 8'h00;
            sh_in = 8'h00;
            last_rx = 8'h00;
            exp_byte = 8'h00;
            bit_pos = 3'd7;
            phase = 1'b0;
            wait_cnt = 16'd0;
            flg = '0;
            flg.lcd_cs_n = 1'b1;
            flg.touch_cs_n = 1'b1;
            flg.dcx = 1'b1;
            cur_mode = MODE_WRITE;
            byte_cnt = 0;
            expected_pins_q.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_we)
                half_cfg = cfg_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_pins_q.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_pins_q.pop_front();
                    compare_field("sck", 16'(rsp_data.sck), 16'(want.sck));
                    compare_field("mosi", 16'(rsp_data.mosi), 16'(want.mosi));
                    compare_field("mosi_drive", 16'(rsp_data.mosi_drive),
                                  16'(want.mosi_drive));
                    compare_field("lcd_cs_n", 16'(rsp_data.lcd_cs_n), 16'(want.lcd_cs_n));
                    compare_field("touch_cs_n", 16'(rsp_data.touch_cs_n),
                                  16'(want.touch_cs_n));
                    compare_field("dcx", 16'(rsp_data.dcx), 16'(want.dcx));
                    compare_field("rx_byte", 16'(rsp_data.rx_byte), 16'(want.rx_byte));
                    compare_field("rx_valid", 16'(rsp_data.rx_valid), 16'(want.rx_valid));
                    compare_field("mismatch", 16'(rsp_data.mismatch), 16'(want.mismatch));
                    compare_field("busy_res", 16'(rsp_data.busy_res), 16'(want.busy_res));
                    compare_field("bytes_done", rsp_data.bytes_done, want.bytes_done);
                end
                checked++;
            end
            if (req_valid && !req_stall)
                expected_pins_q.push_back(predict_pins(req_data));
            pending = expected_pins_q.size();
        end
    end

endmodule

// ===== dv/spi_mode0_master_with_verify_test.sv =====
`timescale 1ns / 1ps
// Testbench top for spi_mode0_master_with_verify: makes request beats, register
// writes and result back-pressure, and gives the verdict.
// Depends on spimv_pkg, the block under test and spimv_checker.
module spi_mode0_master_with_verify_test;
    import spimv_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HALF = 8;
    localparam int REQ_BITS = $bits(req_beat_t);

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [HALF_WIDTH-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_beat_t             req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_beat_t             rsp_data;

    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int transfers = 0;
    int settings_used = 0;
    int cycles = 0;

    always #10 clk = ~clk;

    spi_mode0_master_with_verify uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    spimv_checker pin_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Receiver back-pressure, one fresh draw per cycle.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Random beat with the given opcode; every other field is random.
    function automatic req_beat_t beat_of(logic [1:0] op);
        logic [REQ_BITS-1:0] raw;
        req_beat_t b;
        raw = REQ_BITS'($urandom);
        b = raw;
        b.opcode = op;
        return b;
    endfunction

    // Offer one beat after optional idle cycles and hold it until accepted.
    task automatic send_beat(req_beat_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Tick with both input pins at a level; unless exact, sometimes random.
    task automatic send_tick(logic level, bit exact);
        req_beat_t b;
        b = beat_of(OP_TICK);
        if (exact || $urandom_range(9) != 0)
        begin
            b.touch_data_in = level;
            b.lcd_data_in = level;
        end
        send_beat(b);
    endtask

    // Stop sending and wait until every result beat is in.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_half(logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_data <= HALF_WIDTH'($urandom);
        settings_used++;
    endtask

    // One transfer: begin, setup wait, one to four bytes with their ticks, end.
    task automatic run_transfer(int eff);
        req_beat_t b;
        int        nbytes;
        int        abort_at;
        int        n;
        int        k;
        int        t;
        bit        exact;
        b = beat_of(OP_BEGIN);
        send_beat(b);
        transfers++;
        // With a very long half period only the start of the wait is reached.
        if (eff > LONG_HALF)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(3) == 0)
                    send_beat(beat_of(OP_BYTE));
                send_tick(1'($urandom_range(1)), 1'b0);
            end
            send_beat(beat_of(OP_END));
            return;
        end
        // Setup wait, sometimes with a byte that arrives too early.
        for (t = 0; t < eff; t++)
        begin
            if (t == eff - 1 && $urandom_range(7) == 0)
                send_beat(beat_of(OP_BYTE));
            send_tick(1'($urandom_range(1)), 1'b0);
        end
        nbytes = $urandom_range(1, 4);
        for (n = 0; n < nbytes; n++)
        begin
            b = beat_of(OP_BYTE);
            k = $urandom_range(9);
            b.byte_mode = (k < 3) ? MODE_WRITE : (k < 6) ? MODE_READ :
                          (k < 9) ? MODE_VERIFY : MODE_SPARE;
            k = $urandom_range(7);
            if (k == 0)
                b.tx_byte = 8'h00;
            else if (k == 1)
                b.tx_byte = 8'hFF;
            // Most verify bytes see the expected data on the input pin.
            exact = (b.byte_mode == MODE_VERIFY) && ($urandom_range(3) != 0);
            abort_at = -1;
            if ($urandom_range(19) == 0)
                abort_at = $urandom_range(16 * eff - 1);
            send_beat(b);
            for (t = 0; t < 16 * eff; t++)
            begin
                if (t == abort_at)
                begin
                    send_beat(beat_of(OP_END));
                    return;
                end
                // Begin or byte beats in the middle of a byte are dropped.
                if ($urandom_range(31) == 0)
                    send_beat(beat_of($urandom_range(1) ? OP_BEGIN : OP_BYTE));
                k = 7 - t / (2 * eff);
                if (exact)
                    send_tick(b.tx_byte[k], 1'b1);
                else
                    send_tick(1'($urandom_range(1)), 1'b0);
            end
            repeat ($urandom_range(2)) send_tick(1'($urandom_range(1)), 1'b0);
        end
        send_beat(beat_of(OP_END));
        if ($urandom_range(9) == 0)
            send_beat(beat_of(OP_BYTE));
    endtask

    // Cycle budget for the whole run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d result beats owed", cycles, pending);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int          p;
        int          base;
        int          phase_start;
        int          eff;
        int          t;
        logic [15:0] h;
        logic [15:0] halves [8];
        req_beat_t   b;
        halves = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd65535, 16'd2, 16'd1};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle items, ignored items, and a verify byte that fails.
        send_beat(beat_of(OP_END));
        send_beat(beat_of(OP_TICK));
        b = beat_of(OP_BYTE);
        b.byte_mode = MODE_WRITE;
        b.tx_byte = 8'hFF;
        send_beat(b);
        b = beat_of(OP_BEGIN);
        b.cs_select = 1'b1;
        b.lcd_command = 1'b0;
        b.lcd_release = 1'b0;
        send_beat(b);
        send_beat(beat_of(OP_BYTE));
        send_tick(1'b0, 1'b1);
        b = beat_of(OP_BYTE);
        b.byte_mode = MODE_VERIFY;
        b.tx_byte = 8'hFF;
        send_beat(b);
        send_beat(beat_of(OP_BEGIN));
        for (t = 0; t < 16; t++)
            send_tick(1'b0, 1'b1);
        send_beat(beat_of(OP_BYTE));
        send_beat(beat_of(OP_END));
        drain();

        // Random phases, each with its own half period and flow-control mix.
        base = items_sent;
        p = 0;
        while (items_sent - base < ITEM_TARGET)
        begin
            h = halves[p % 8];
            write_half(h);
            eff = (h == 16'd0) ? 1 : h;
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct = 28;
                    stall_pct = 28;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 3)) send_beat(beat_of(2'($urandom_range(3))));
                run_transfer(eff);
            end
            idle_pct = 0;
            stall_pct = 0;
            drain();
            p++;
        end

        repeat (8) @(posedge clk);
        $display("Summary: %0d request beats in %0d transfers over %0d register settings, %0d %s",
                 items_sent, transfers, settings_used, checked, "result beats checked.");
        $display("Covered all byte modes, aborts, ignored items and four back-pressure mixes.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
